>>> hw/rtl/tcs_pkg.sv
// Shared types, constants and the sine table for the turtle command stepper.
package tcs_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int INT_BITS_DEF  = 16;

  localparam int STEP_W    = 12;
  localparam int ANGLE_W   = 9;
  localparam int SYM_W     = 8;
  localparam int SINE_W    = 31;   // unsigned Q1.30 magnitude, at most 2^30
  localparam int SINE_IDX_W = 7;   // quarter-wave index 0..90
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 12;
  localparam int OUT_POS_W = 32;

  localparam logic [ANGLE_W-1:0] DEG_90  = 9'd90;
  localparam logic [ANGLE_W-1:0] DEG_180 = 9'd180;
  localparam logic [ANGLE_W-1:0] DEG_270 = 9'd270;
  localparam logic [ANGLE_W-1:0] DEG_360 = 9'd360;

  localparam logic [SYM_W-1:0] SYM_LEFT    = 8'h2B;  // '+'
  localparam logic [SYM_W-1:0] SYM_RIGHT   = 8'h2D;  // '-'
  localparam logic [SYM_W-1:0] SYM_FORWARD = 8'h46;  // 'F'

  localparam logic [CFG_IDX_W-1:0] REG_STEP_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_ANGLE  = 1'd1;

  localparam logic [STEP_W-1:0]  STEP_RESET = 12'd1;
  localparam logic [ANGLE_W-1:0] TURN_RESET = 9'd90;

  typedef enum logic [1:0] {
    KIND_TURN    = 2'd0,
    KIND_MOVE    = 2'd1,
    KIND_UNKNOWN = 2'd2
  } kind_t;

  // Signed trig value as magnitude and sign.
  typedef struct packed {
    logic [SINE_W-1:0] mag;
    logic              neg;
  } trig_t;

  typedef logic [90:0][SINE_W-1:0] sine_tab_t;

  // Eight-term Taylor series in Q30 with truncating steps, clamped to 1.0.
  // Only evaluated at elaboration to build the table.
  function automatic logic [SINE_W-1:0] sine_q30(input int unsigned d);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    x    = (longint'(d) * 64'd3373259426) / 180;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 6;
    sum  = (sum > term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 42;
    sum  = (sum > term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 110;
    sum  = (sum > term) ? sum - term : 64'd0;
    term = ((term * x2) >> 30) / 156;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 210;
    sum  = (sum > term) ? sum - term : 64'd0;
    if (sum > 64'd1073741824) begin
      sum = 64'd1073741824;
    end
    return sum[SINE_W-1:0];
  endfunction

  function automatic sine_tab_t build_sine_table();
    sine_tab_t tab;
    for (int d = 0; d <= 90; d++) begin
      tab[d] = sine_q30(d);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TABLE = build_sine_table();

endpackage

>>> hw/rtl/tcs_trig.sv
// Heading to sine and cosine lookup through the quarter-wave table.
module tcs_trig (
  input  logic [tcs_pkg::ANGLE_W-1:0] heading_i,
  output tcs_pkg::trig_t              sin_o,
  output tcs_pkg::trig_t              cos_o
);
  import tcs_pkg::*;

  logic [ANGLE_W-1:0] cos_angle;
  logic [ANGLE_W-1:0] cos_sum;

  function automatic trig_t signed_sine(input logic [ANGLE_W-1:0] h);
    trig_t             r;
    logic [ANGLE_W-1:0] idx;
    if (h <= DEG_90) begin
      idx   = h;
      r.neg = 1'b0;
    end else if (h <= DEG_180) begin
      idx   = DEG_180 - h;
      r.neg = 1'b0;
    end else if (h <= DEG_270) begin
      idx   = h - DEG_180;
      r.neg = 1'b1;
    end else begin
      idx   = DEG_360 - h;
      r.neg = 1'b1;
    end
    r.mag = SINE_TABLE[idx[SINE_IDX_W-1:0]];
    return r;
  endfunction

  // cos(h) = sin(h + 90), wrapped into 0..359.
  assign cos_sum   = heading_i + DEG_90;
  assign cos_angle = (cos_sum >= DEG_360) ? cos_sum - DEG_360 : cos_sum;

  assign sin_o = signed_sine(heading_i);
  assign cos_o = signed_sine(cos_angle);

endmodule

>>> hw/rtl/tcs_axis.sv
// One coordinate update: scale, round, add, snap and clamp.
module tcs_axis #(
  parameter int FRAC_BITS = tcs_pkg::FRAC_BITS_DEF,
  parameter int INT_BITS  = tcs_pkg::INT_BITS_DEF
) (
  input  logic [INT_BITS+FRAC_BITS-1:0] pos_i,
  input  tcs_pkg::trig_t                trig_i,
  input  logic [tcs_pkg::STEP_W-1:0]    step_i,
  output logic [INT_BITS+FRAC_BITS-1:0] pos_o,
  output logic                          sat_o
);
  import tcs_pkg::*;

  localparam int POS_BITS = INT_BITS + FRAC_BITS;
  localparam int SH       = 30 - FRAC_BITS;
  localparam int PROD_W   = SINE_W + STEP_W;
  localparam int MAG_W    = PROD_W + 1 - SH;
  localparam int SW       = ((POS_BITS > MAG_W) ? POS_BITS : MAG_W) + 2;
  localparam logic [PROD_W:0]       HALF    = (PROD_W + 1)'(1) << (SH - 1);
  localparam logic [POS_BITS-1:0]   POS_MAX = '1;

  logic [PROD_W-1:0]     prod;
  logic [PROD_W:0]       rnd;
  logic [MAG_W-1:0]      mag_r;
  logic signed [SW-1:0]  old_s;
  logic signed [SW-1:0]  delta_s;
  logic signed [SW-1:0]  sum_s;
  logic signed [SW-1:0]  snap_s;
  logic [FRAC_BITS-1:0]  frac;

  assign prod  = PROD_W'(trig_i.mag) * PROD_W'(step_i);
  // Round half up on the magnitude, then apply the sign.
  assign rnd   = {1'b0, prod} + HALF;
  assign mag_r = rnd[PROD_W:SH];

  assign old_s   = signed'(SW'(pos_i));
  assign delta_s = trig_i.neg ? -signed'(SW'(mag_r)) : signed'(SW'(mag_r));
  assign sum_s   = old_s + delta_s;
  assign frac    = sum_s[FRAC_BITS-1:0];

  always_comb begin
    if (frac <= FRAC_BITS'(1)) begin
      snap_s = {sum_s[SW-1:FRAC_BITS], {FRAC_BITS{1'b0}}};
    end else if (&frac) begin
      snap_s = sum_s + SW'(1);
    end else begin
      snap_s = sum_s;
    end
  end

  always_comb begin
    sat_o = 1'b0;
    if (snap_s[SW-1]) begin
      pos_o = '0;
    end else if (snap_s >= signed'(SW'(POS_MAX))) begin
      pos_o = POS_MAX;
      sat_o = 1'b1;
    end else begin
      pos_o = snap_s[POS_BITS-1:0];
    end
  end

endmodule

>>> hw/rtl/turtle_command_stepper.sv
// Top level of the turtle command stepper: handshakes, state and result register.
// This block takes one turtle command byte per transfer and returns one
// result per command, carrying the kind of command, the position and the
// heading after it, and a saturation flag. '+' and '-' turn by the
// configured angle, 'F' moves by the configured step length along the
// heading, and any other byte is reported as unknown with the state left
// alone. The block sustains one symbol per clock while the result side is
// not stalled. A symbol is captured in an input register. When the result
// register is free or being emptied, the heading and position update and the
// result is written to the output register, from which it is offered.
// The state loop runs from the heading register through the sine table, one
// 31x12 multiply per axis and the round, snap and clamp logic back into the
// position registers. Backpressure on the result side stalls the input
// register and then the input side, so at most two commands are held inside.
// Configuration is always accepted. A turn angle write keeps the low 9 bits
// of the data and reduces a value above 359 by 360 when it is written.
// Write configuration only while no command is in flight.
module turtle_command_stepper #(
  parameter int FRAC_BITS = tcs_pkg::FRAC_BITS_DEF,
  parameter int INT_BITS  = tcs_pkg::INT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Configuration writes.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcs_pkg::CFG_DATA_W-1:0] cfg_data,
  // Command symbols.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] symbol
  // Results.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [79:0]                    out_tdata,  // [31:0] pos_x, [63:32] pos_y,
                                                     // [72:64] heading, [79:73] zero
  output logic [2:0]                     out_tuser   // [1:0] kind, [2] saturated
);
  import tcs_pkg::*;

  localparam int POS_BITS = INT_BITS + FRAC_BITS;

  logic [STEP_W-1:0]   step_len_r;
  logic [ANGLE_W-1:0]  turn_r;
  logic [ANGLE_W-1:0]  turn_wr;

  logic [ANGLE_W-1:0]  heading_r, heading_nxt;
  logic [POS_BITS-1:0] pos_x_r, pos_x_nxt;
  logic [POS_BITS-1:0] pos_y_r, pos_y_nxt;

  logic [SYM_W-1:0]    sym_r;
  logic                in_valid_r;
  logic                advance;

  kind_t               kind_nxt;
  logic                sat_nxt;

  logic                out_valid_r;
  kind_t               out_kind_r;
  logic                out_sat_r;
  logic [OUT_POS_W-1:0] out_pos_x_r;
  logic [OUT_POS_W-1:0] out_pos_y_r;
  logic [ANGLE_W-1:0]  out_heading_r;
  logic [63:0]         pos_x_wide;
  logic [63:0]         pos_y_wide;

  trig_t               sin_v, cos_v;
  logic [POS_BITS-1:0] move_x, move_y;
  logic                sat_x, sat_y;

  logic [ANGLE_W:0]    turn_left_sum;
  logic [ANGLE_W:0]    turn_right_sum;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;
  assign turn_wr   = (cfg_data[ANGLE_W-1:0] >= DEG_360) ?
                     cfg_data[ANGLE_W-1:0] - DEG_360 : cfg_data[ANGLE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_len_r <= STEP_RESET;
      turn_r     <= TURN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_STEP_LENGTH: step_len_r <= cfg_data[STEP_W-1:0];
        REG_TURN_ANGLE:  turn_r     <= turn_wr;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. The held symbol moves on when the result register is
  // empty or its contents are being taken in the same cycle.
  // ---------------------------------------------------------------------------
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      sym_r <= in_tdata[SYM_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Command execution.
  // ---------------------------------------------------------------------------
  tcs_trig u_trig (
    .heading_i (heading_r),
    .sin_o     (sin_v),
    .cos_o     (cos_v)
  );

  tcs_axis #(
    .FRAC_BITS (FRAC_BITS),
    .INT_BITS  (INT_BITS)
  ) u_axis_x (
    .pos_i  (pos_x_r),
    .trig_i (cos_v),
    .step_i (step_len_r),
    .pos_o  (move_x),
    .sat_o  (sat_x)
  );

  tcs_axis #(
    .FRAC_BITS (FRAC_BITS),
    .INT_BITS  (INT_BITS)
  ) u_axis_y (
    .pos_i  (pos_y_r),
    .trig_i (sin_v),
    .step_i (step_len_r),
    .pos_o  (move_y),
    .sat_o  (sat_y)
  );

  // Both sums stay below 720, so one conditional subtract wraps them.
  assign turn_left_sum  = {1'b0, heading_r} + {1'b0, turn_r};
  assign turn_right_sum = {1'b0, heading_r} + {1'b0, DEG_360} - {1'b0, turn_r};

  always_comb begin
    heading_nxt = heading_r;
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    kind_nxt    = KIND_UNKNOWN;
    sat_nxt     = 1'b0;
    unique case (sym_r)
      SYM_LEFT: begin
        heading_nxt = (turn_left_sum >= {1'b0, DEG_360}) ?
                      ANGLE_W'(turn_left_sum - {1'b0, DEG_360}) :
                      turn_left_sum[ANGLE_W-1:0];
        kind_nxt    = KIND_TURN;
      end
      SYM_RIGHT: begin
        heading_nxt = (turn_right_sum >= {1'b0, DEG_360}) ?
                      ANGLE_W'(turn_right_sum - {1'b0, DEG_360}) :
                      turn_right_sum[ANGLE_W-1:0];
        kind_nxt    = KIND_TURN;
      end
      SYM_FORWARD: begin
        pos_x_nxt = move_x;
        pos_y_nxt = move_y;
        sat_nxt   = sat_x || sat_y;
        kind_nxt  = KIND_MOVE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_r <= '0;
      pos_x_r   <= '0;
      pos_y_r   <= '0;
    end else if (advance) begin
      heading_r <= heading_nxt;
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register. Positions wider than 32 bits report their low 32 bits.
  // ---------------------------------------------------------------------------
  assign pos_x_wide = 64'(pos_x_nxt);
  assign pos_y_wide = 64'(pos_y_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_kind_r    <= kind_nxt;
      out_sat_r     <= sat_nxt;
      out_heading_r <= heading_nxt;
      out_pos_x_r   <= pos_x_wide[OUT_POS_W-1:0];
      out_pos_y_r   <= pos_y_wide[OUT_POS_W-1:0];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_heading_r, out_pos_y_r, out_pos_x_r};
  assign out_tuser  = {out_sat_r, out_kind_r};

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // The heading register wraps into 0..359.
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    heading_r < DEG_360)
    else $error("heading left the 0..359 range");

  // Saturation is only reported on forward moves.
  a_sat_move_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sat_r |-> out_kind_r == KIND_MOVE)
    else $error("saturation flag on a non-move result");

  // Turtle state only changes when a command moves into the result register.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(heading_r) && $stable(pos_x_r) && $stable(pos_y_r))
    else $error("turtle state changed without a command");

  // A turn or an unknown symbol leaves the position alone.
  a_turn_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    advance && kind_nxt != KIND_MOVE |=> $stable(pos_x_r) && $stable(pos_y_r))
    else $error("position changed on a non-move command");

endmodule
